// ===== hdl/dtwtm_pkg.sv =====
`timescale 1ns / 1ps

package dtwtm_pkg;

  // Reset values of the configuration registers
  localparam logic [15:0] ACK_TIMEOUT_RESET = 16'h0100;
  localparam logic [7:0]  PHASE_TICKS_RESET = 8'h01;

  // Bit counts of the serial frame and the parity sample limit
  localparam logic [4:0] INST_BITS    = 5'd8;
  localparam logic [4:0] WORD_BITS    = 5'd16;
  localparam logic [1:0] PARITY_TRIES = 2'd3;

  // Configuration register indexes
  localparam logic CFG_ACK_TIMEOUT = 1'b0;
  localparam logic CFG_PHASE_TICKS = 1'b1;

  // Transaction kinds
  localparam logic [1:0] CMD_CONTROL = 2'd0;
  localparam logic [1:0] CMD_WRITE   = 2'd1;
  localparam logic [1:0] CMD_READ    = 2'd2;

  // Completion status codes
  localparam logic [1:0] STATUS_OK          = 2'd0;
  localparam logic [1:0] STATUS_NO_ACK_INST = 2'd1;
  localparam logic [1:0] STATUS_NO_ACK_DATA = 2'd2;
  localparam logic [1:0] STATUS_PARITY      = 2'd3;

  typedef enum logic [4:0] {
    PH_IDLE   = 5'd0,
    PH_ST1    = 5'd1,
    PH_ST2    = 5'd2,
    PH_ST3    = 5'd3,
    PH_IL     = 5'd4,
    PH_IH     = 5'd5,
    PH_A1PREP = 5'd6,
    PH_A1POLL = 5'd7,
    PH_DL     = 5'd8,
    PH_DH     = 5'd9,
    PH_WPL    = 5'd10,
    PH_WPH    = 5'd11,
    PH_A2PREP = 5'd12,
    PH_A2POLL = 5'd13,
    PH_RH     = 5'd14,
    PH_RL     = 5'd15,
    PH_RPL    = 5'd16,
    PH_RPH    = 5'd17,
    PH_RPS    = 5'd18,
    PH_SP1    = 5'd19,
    PH_SP2    = 5'd20
  } phase_t;

  typedef struct packed {
    logic        request_valid;
    logic [1:0]  command;
    logic [7:0]  instruction;
    logic [15:0] write_word;
    logic        sda_in;
  } tick_in_t;

  typedef struct packed {
    logic        scl;
    logic        sda_out;
    logic        sda_drive;
    logic        busy_res;
    logic        done_res;
    logic [1:0]  status;
    logic [15:0] read_word;
  } tick_out_t;

endpackage

// ===== hdl/debug_two_wire_transaction_master.sv =====
`timescale 1ns / 1ps

// Two-wire debug-port transaction master. Each input transaction is one pin-phase
// tick: it carries an optional request (control, write or read) and the sampled
// data line, and it yields exactly one result transaction with the pin levels for
// that tick (taken from the phase held at the start of the tick), busy, a done
// pulse with its status, and the last successfully read word. A transaction on
// the wire is a start condition, an 8-bit instruction MSB first and an ACK wait
// bounded by ack_timeout plus one polls; a write adds 16 data bits, a parity bit
// and a second ACK, a read shifts in 16 bits and samples parity on up to three
// ticks, and a stop ends everything. One input transaction is taken every clock
// cycle unless out_ready stalls the result register: the bit-level state machine
// is combinational logic between its state registers and the result register,
// which frees up in the same cycle it is taken. Requests while busy and command
// code three are ignored. Configuration (index 0 is ack_timeout, index 1 is
// phase_ticks, where zero acts as one) is for the user to write only while idle;
// the block does not enforce it. cfg_ready is always high.
module debug_two_wire_transaction_master
  import dtwtm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  tick_in_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output tick_out_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  // Configuration registers
  logic [15:0] ack_timeout;
  logic [7:0]  phase_ticks;

  // Bit-level state
  phase_t      phase,         phase_next;
  logic [4:0]  bit_count,     bit_count_next;
  logic [15:0] shift_word,    shift_word_next;
  logic        parity_acc,    parity_acc_next;
  logic [15:0] wait_count,    wait_count_next;
  logic [7:0]  tick_count,    tick_count_next;
  logic [1:0]  kind_reg,      kind_reg_next;
  logic [15:0] received_word, received_word_next;
  logic [1:0]  parity_tries,  parity_tries_next;
  logic [15:0] data_latch,    data_latch_next;
  logic [1:0]  fail_code,     fail_code_next;

  tick_out_t   result;
  logic        accept;

  // Phase timing helpers
  logic [7:0]  ticks_eff;
  logic [8:0]  tick_inc;
  logic        phase_done;
  logic [7:0]  tick_after;
  logic [4:0]  bit_inc;
  logic [1:0]  tries_inc;
  logic        sda;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign accept    = in_valid && in_ready;
  assign sda       = in_data.sda_in;

  // A phase ends on the tick whose count reaches phase_ticks
  assign ticks_eff  = (phase_ticks == 8'd0) ? 8'd1 : phase_ticks;
  assign tick_inc   = {1'b0, tick_count} + 9'd1;
  assign phase_done = tick_inc >= {1'b0, ticks_eff};
  assign tick_after = phase_done ? 8'd0 : tick_inc[7:0];
  assign bit_inc    = bit_count + 5'd1;
  assign tries_inc  = parity_tries + 2'd1;

  always_comb begin
    phase_next         = phase;
    bit_count_next     = bit_count;
    shift_word_next    = shift_word;
    parity_acc_next    = parity_acc;
    wait_count_next    = wait_count;
    tick_count_next    = tick_count;
    kind_reg_next      = kind_reg;
    received_word_next = received_word;
    parity_tries_next  = parity_tries;
    data_latch_next    = data_latch;
    fail_code_next     = fail_code;

    // Pin levels follow the phase held at the start of the tick
    result.scl       = 1'b1;
    result.sda_out   = 1'b1;
    result.sda_drive = 1'b1;
    result.busy_res  = (phase != PH_IDLE);
    result.done_res  = 1'b0;
    result.status    = STATUS_OK;

    unique case (phase)
      PH_ST1: begin
        result.scl = 1'b1; result.sda_out = 1'b1;
      end
      PH_ST2, PH_SP2: begin
        result.scl = 1'b1; result.sda_out = 1'b0;
      end
      PH_ST3, PH_SP1: begin
        result.scl = 1'b0; result.sda_out = 1'b0;
      end
      PH_IL: begin
        result.scl = 1'b0; result.sda_out = shift_word[7];
      end
      PH_IH: begin
        result.scl = 1'b1; result.sda_out = shift_word[7];
      end
      PH_DL: begin
        result.scl = 1'b0; result.sda_out = shift_word[15];
      end
      PH_DH: begin
        result.scl = 1'b1; result.sda_out = shift_word[15];
      end
      PH_WPL: begin
        result.scl = 1'b0; result.sda_out = parity_acc;
      end
      PH_WPH: begin
        result.scl = 1'b1; result.sda_out = parity_acc;
      end
      PH_A1POLL, PH_A2POLL, PH_RH, PH_RPH, PH_RPS: begin
        // Release the data line; report it low while released
        result.scl = 1'b1; result.sda_out = 1'b0; result.sda_drive = 1'b0;
      end
      PH_RL, PH_RPL: begin
        result.scl = 1'b0; result.sda_out = 1'b0; result.sda_drive = 1'b0;
      end
      default: begin
      end
    endcase

    unique case (phase)
      PH_ST1, PH_IL, PH_DL, PH_WPL, PH_RPL, PH_SP1, PH_ST2, PH_WPH: begin
        tick_count_next = tick_after;
        if (phase_done) begin
          unique case (phase)
            PH_ST1:  phase_next = PH_ST2;
            PH_ST2:  phase_next = PH_ST3;
            PH_IL:   phase_next = PH_IH;
            PH_DL:   phase_next = PH_DH;
            PH_WPL:  phase_next = PH_WPH;
            PH_WPH:  phase_next = PH_A2PREP;
            PH_RPL:  phase_next = PH_RPH;
            default: phase_next = PH_SP2;
          endcase
        end
      end
      PH_ST3: begin
        tick_count_next = tick_after;
        if (phase_done) begin
          bit_count_next = 5'd0;
          phase_next     = PH_IL;
        end
      end
      PH_IH: begin
        tick_count_next = tick_after;
        if (phase_done) begin
          shift_word_next = {shift_word[14:0], 1'b0};
          bit_count_next  = bit_inc;
          phase_next      = (bit_inc >= INST_BITS) ? PH_A1PREP : PH_IL;
        end
      end
      PH_A1PREP, PH_A2PREP: begin
        tick_count_next = tick_after;
        if (phase_done) begin
          wait_count_next = ack_timeout;
          phase_next      = (phase == PH_A1PREP) ? PH_A1POLL : PH_A2POLL;
        end
      end
      PH_A1POLL: begin
        priority if (!sda) begin
          bit_count_next  = 5'd0;
          parity_acc_next = 1'b0;
          tick_count_next = 8'd0;
          if (kind_reg == CMD_WRITE) begin
            shift_word_next = data_latch;
            phase_next      = PH_DL;
          end else if (kind_reg == CMD_READ) begin
            shift_word_next = 16'd0;
            phase_next      = PH_RH;
          end else begin
            phase_next = PH_SP1;
          end
        end else if (wait_count == 16'd0) begin
          fail_code_next  = STATUS_NO_ACK_INST;
          tick_count_next = 8'd0;
          phase_next      = PH_SP1;
        end else begin
          wait_count_next = wait_count - 16'd1;
        end
      end
      PH_DH: begin
        tick_count_next = tick_after;
        if (phase_done) begin
          parity_acc_next = parity_acc ^ shift_word[15];
          shift_word_next = {shift_word[14:0], 1'b0};
          bit_count_next  = bit_inc;
          phase_next      = (bit_inc >= WORD_BITS) ? PH_WPL : PH_DL;
        end
      end
      PH_A2POLL: begin
        priority if (!sda) begin
          tick_count_next = 8'd0;
          phase_next      = PH_SP1;
        end else if (wait_count == 16'd0) begin
          fail_code_next  = STATUS_NO_ACK_DATA;
          tick_count_next = 8'd0;
          phase_next      = PH_SP1;
        end else begin
          wait_count_next = wait_count - 16'd1;
        end
      end
      PH_RH: begin
        tick_count_next = tick_after;
        if (phase_done) begin
          shift_word_next = {shift_word[14:0], sda};
          parity_acc_next = parity_acc ^ sda;
          phase_next      = PH_RL;
        end
      end
      PH_RL: begin
        tick_count_next = tick_after;
        if (phase_done) begin
          bit_count_next = bit_inc;
          phase_next     = (bit_inc >= WORD_BITS) ? PH_RPL : PH_RH;
        end
      end
      PH_RPH: begin
        tick_count_next = tick_after;
        if (phase_done) begin
          parity_tries_next = 2'd0;
          phase_next        = PH_RPS;
        end
      end
      PH_RPS: begin
        // One parity sample a tick; keep the word only on a match
        if (sda == parity_acc) begin
          received_word_next = shift_word;
          tick_count_next    = 8'd0;
          phase_next         = PH_SP1;
        end else begin
          parity_tries_next = tries_inc;
          if (tries_inc >= PARITY_TRIES) begin
            fail_code_next  = STATUS_PARITY;
            tick_count_next = 8'd0;
            phase_next      = PH_SP1;
          end
        end
      end
      PH_SP2: begin
        tick_count_next = tick_after;
        if (phase_done) begin
          phase_next      = PH_IDLE;
          result.done_res = 1'b1;
          result.status   = fail_code;
        end
      end
      default: begin
        // Idle: latch a new request; command code three is dropped
        phase_next = PH_IDLE;
        if (in_data.request_valid && (in_data.command <= CMD_READ)) begin
          kind_reg_next     = in_data.command;
          shift_word_next   = {8'd0, in_data.instruction};
          data_latch_next   = in_data.write_word;
          bit_count_next    = 5'd0;
          parity_acc_next   = 1'b0;
          parity_tries_next = 2'd0;
          wait_count_next   = 16'd0;
          fail_code_next    = STATUS_OK;
          tick_count_next   = 8'd0;
          phase_next        = PH_ST1;
        end
      end
    endcase

    result.read_word = received_word_next;
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ack_timeout <= ACK_TIMEOUT_RESET;
      phase_ticks <= PHASE_TICKS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ACK_TIMEOUT: ack_timeout <= cfg_data;
        CFG_PHASE_TICKS: phase_ticks <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  // Advance the state machine once per accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      bit_count     <= 5'd0;
      shift_word    <= 16'd0;
      parity_acc    <= 1'b0;
      wait_count    <= 16'd0;
      tick_count    <= 8'd0;
      kind_reg      <= CMD_CONTROL;
      received_word <= 16'd0;
      parity_tries  <= 2'd0;
      data_latch    <= 16'd0;
      fail_code     <= STATUS_OK;
    end else if (accept) begin
      phase         <= phase_next;
      bit_count     <= bit_count_next;
      shift_word    <= shift_word_next;
      parity_acc    <= parity_acc_next;
      wait_count    <= wait_count_next;
      tick_count    <= tick_count_next;
      kind_reg      <= kind_reg_next;
      received_word <= received_word_next;
      parity_tries  <= parity_tries_next;
      data_latch    <= data_latch_next;
      fail_code     <= fail_code_next;
    end
  end

  // Result register: hold until taken, refill in the same cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= result;
    end
  end

endmodule
